@@ hdl/mdb_pkg.sv @@
// Shared constants, payload types and sine table builder for the multichannel delay.
`default_nettype none
package mdb_pkg;

  localparam int MAX_CHANNELS     = 8;
  localparam int MAX_DELAY_FRAMES = 32768;
  localparam int SINE_TABLE_BITS  = 10;

  localparam int SAMPLE_W       = 24;
  localparam int CHANNEL_OUT_W  = 3;
  localparam int DELAY_REG_W    = 16;
  localparam int CHANNELS_REG_W = 4;
  localparam int PHASE_W        = 32;
  localparam int VOLUME_W       = 16;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_INDEX_W    = 2;

  localparam int STORE_DEPTH  = MAX_DELAY_FRAMES * MAX_CHANNELS;
  localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);
  localparam int FRAME_W      = $clog2(MAX_DELAY_FRAMES);
  localparam int FILL_W       = $clog2(MAX_DELAY_FRAMES + 1);
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CHANS_W      = $clog2(MAX_CHANNELS + 1);
  localparam int SINE_DEPTH   = 1 << SINE_TABLE_BITS;
  localparam int FULL_SCALE   = 8388607;

  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598668;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172273;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DELAY_FRAMES  = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_PHASE_STEP    = 2'd2,
    REG_BEEP_VOLUME   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       mute;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic [CHANNEL_OUT_W-1:0]    channel;
  } out_item_t;

  typedef logic signed [SAMPLE_W-1:0] sine_tab_t [SINE_DEPTH];

  function automatic logic [63:0] mulq30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] prod;
    prod = a * b;
    return prod >> 30;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int k);
    int          qbits;
    int          quarter;
    int          quad;
    int          r;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] mag;
    qbits   = SINE_TABLE_BITS - 2;
    quarter = 1 << qbits;
    quad    = (k >> qbits) & 3;
    r       = k & (quarter - 1);
    if ((quad & 1) != 0) begin
      r = quarter - r;
    end
    u  = 64'(r) << (30 - qbits);
    u2 = mulq30(u, u);
    p  = C9;
    p  = C7 - mulq30(u2, p);
    p  = C5 - mulq30(u2, p);
    p  = C3 - mulq30(u2, p);
    p  = C1 - mulq30(u2, p);
    s  = mulq30(u, p);
    if (s > (64'd1 << 30)) begin
      s = 64'd1 << 30;
    end
    mag = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
    if ((quad & 2) != 0) begin
      mag = -mag;
    end
    return mag[SAMPLE_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_table();
    sine_tab_t tab;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

@@ hdl/mdb_ring_ram.sv @@
// Single-port read-first synchronous RAM holding the delay ring.
`default_nettype none
module mdb_ring_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
      if (we) begin
        mem[addr] <= wdata;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/mdb_sine_rom.sv @@
// Registered-read sine ROM for the beep generator.
`default_nettype none
module mdb_sine_rom
  import mdb_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [SINE_TABLE_BITS-1:0]  addr,
  output logic signed [SAMPLE_W-1:0]       rdata
);

  localparam sine_tab_t SINE_ROM = build_sine_table();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= SINE_ROM[addr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/multichannel_delay_with_beep.sv @@
// Top level of the multichannel audio delay line with mute beep.
//
// Takes one interleaved sample request per clock while the output side is ready and returns one
// result per request through the s1 stage and the output register; the sustained rate is one
// sample per cycle, set by the single read-first port of the ring RAM, which reads the delayed
// sample and stores the new one at the same address in the accepting cycle. The ring holds
// MAX_DELAY_FRAMES frames of MAX_CHANNELS samples and needs no clearing pass: outputs are
// zero until the configured delay has filled once. With a nonzero delay, a frame whose
// channel 0 request carries mute emits a volume-scaled sine beep on every channel, and the
// beep phase advances once per muted frame. Write the registers only while no request is
// in flight; writing the delay or channel count restarts the ring position and fill.
`default_nettype none
module multichannel_delay_with_beep
  import mdb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   src_valid,
  output logic                        src_ready,
  input  wire in_item_t               src_data,
  output logic                        dst_valid,
  input  wire logic                   dst_ready,
  output out_item_t                   dst_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [DELAY_REG_W-1:0]    delay_frames;
  logic [CHANNELS_REG_W-1:0] channel_count;
  logic [PHASE_W-1:0]        phase_step;
  logic [VOLUME_W-1:0]       beep_volume;

  logic [FRAME_W-1:0]      write_frame;
  logic [STORE_ADDR_W-1:0] frame_base;
  logic [FILL_W-1:0]       fill_count;
  logic [CH_W-1:0]         channel_pos;
  logic [PHASE_W-1:0]      beep_phase;
  logic                    beep_on;
  logic [SAMPLE_W-1:0]     beep_val;

  logic                    s1_valid;
  logic                    s1_pass;
  logic                    s1_use_store;
  logic                    s1_beep;
  logic                    s1_beep_new;
  logic [SAMPLE_W-1:0]     s1_sample;
  logic [CH_W-1:0]         s1_channel;

  logic                    accept;
  logic                    s1_adv;
  logic [CHANS_W-1:0]      chans_eff;
  logic [FILL_W-1:0]       delay_eff;
  logic                    pass;
  logic                    last;
  logic                    beep_start;
  logic                    beep_on_next;
  logic [CH_W-1:0]         channel_pos_next;
  logic [STORE_ADDR_W-1:0] ring_addr;
  logic [SAMPLE_W-1:0]     ring_q;
  logic signed [SAMPLE_W-1:0] sine_q;
  logic [SAMPLE_W-1:0]     sine_mag;
  logic [39:0]             beep_prod;
  logic [SAMPLE_W-1:0]     beep_scaled;
  logic [SAMPLE_W-1:0]     beep_calc;
  logic [SAMPLE_W-1:0]     result;
  logic [31:0]             channel_wide;

  assign accept    = src_valid && src_ready;
  assign s1_adv    = s1_valid && (!dst_valid || dst_ready);
  assign src_ready = !s1_valid || !dst_valid || dst_ready;

  always_comb begin
    if (channel_count == '0) begin
      chans_eff = CHANS_W'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      chans_eff = CHANS_W'(MAX_CHANNELS);
    end else begin
      chans_eff = CHANS_W'(channel_count);
    end
    if (32'(delay_frames) > MAX_DELAY_FRAMES) begin
      delay_eff = FILL_W'(MAX_DELAY_FRAMES);
    end else begin
      delay_eff = FILL_W'(delay_frames);
    end
  end

  assign pass             = (delay_eff == '0);
  assign last             = (32'(channel_pos) + 32'd1 >= 32'(chans_eff));
  assign channel_pos_next = last ? '0 : channel_pos + CH_W'(1);
  assign beep_start       = !pass && (channel_pos == '0) && src_data.mute;
  assign beep_on_next     = (!pass && (channel_pos == '0)) ? src_data.mute : beep_on;
  assign ring_addr        = frame_base + STORE_ADDR_W'(channel_pos);

  mdb_ring_ram #(
    .DATA_W (SAMPLE_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (STORE_ADDR_W)
  ) u_ring (
    .clk   (clk),
    .en    (accept && !pass),
    .we    (accept && !pass),
    .addr  (ring_addr),
    .wdata (src_data.sample),
    .rdata (ring_q)
  );

  mdb_sine_rom u_sine (
    .clk   (clk),
    .rd_en (accept),
    .addr  (beep_phase[PHASE_W-1 -: SINE_TABLE_BITS]),
    .rdata (sine_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_frames  <= '0;
      channel_count <= CHANNELS_REG_W'(1);
      phase_step    <= '0;
      beep_volume   <= '0;
      write_frame   <= '0;
      frame_base    <= '0;
      fill_count    <= '0;
      channel_pos   <= '0;
      beep_phase    <= '0;
      beep_on       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELAY_FRAMES: begin
          delay_frames <= cfg_data[DELAY_REG_W-1:0];
          write_frame  <= '0;
          frame_base   <= '0;
          fill_count   <= '0;
          channel_pos  <= '0;
          beep_on      <= 1'b0;
        end
        REG_CHANNEL_COUNT: begin
          channel_count <= cfg_data[CHANNELS_REG_W-1:0];
          write_frame   <= '0;
          frame_base    <= '0;
          fill_count    <= '0;
          channel_pos   <= '0;
          beep_on       <= 1'b0;
        end
        REG_PHASE_STEP:  phase_step  <= cfg_data[PHASE_W-1:0];
        REG_BEEP_VOLUME: beep_volume <= cfg_data[VOLUME_W-1:0];
        default: ;
      endcase
    end else if (accept) begin
      channel_pos <= channel_pos_next;
      beep_on     <= beep_on_next;
      if (beep_start) begin
        beep_phase <= beep_phase + phase_step;
      end
      if (!pass && last) begin
        if (32'(write_frame) + 32'd1 >= 32'(delay_eff)) begin
          write_frame <= '0;
          frame_base  <= '0;
        end else begin
          write_frame <= write_frame + FRAME_W'(1);
          frame_base  <= frame_base + STORE_ADDR_W'(chans_eff);
        end
        if (fill_count < delay_eff) begin
          fill_count <= fill_count + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pass      <= pass;
      s1_use_store <= !pass && (fill_count >= delay_eff);
      s1_beep      <= !pass && beep_on_next;
      s1_beep_new  <= beep_start;
      s1_sample    <= src_data.sample;
      s1_channel   <= channel_pos;
    end
  end

  always_comb begin
    sine_mag    = sine_q[SAMPLE_W-1] ? SAMPLE_W'(-sine_q) : SAMPLE_W'(sine_q);
    beep_prod   = 40'(sine_mag) * 40'(beep_volume) + 40'd32768;
    beep_scaled = beep_prod[16 +: SAMPLE_W];
    beep_calc   = sine_q[SAMPLE_W-1] ? -beep_scaled : beep_scaled;
    if (s1_pass) begin
      result = s1_sample;
    end else if (s1_beep) begin
      result = s1_beep_new ? beep_calc : beep_val;
    end else if (s1_use_store) begin
      result = ring_q;
    end else begin
      result = '0;
    end
    channel_wide = 32'(s1_channel);
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_beep_new) begin
      beep_val <= beep_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (s1_adv) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      dst_data.sample_out <= result;
      dst_data.channel    <= channel_wide[CHANNEL_OUT_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ hdl/mdb_checker.sv @@
// Port-level assertions for the multichannel delay, bound to the top level.
`default_nettype none
module mdb_checker
  import mdb_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      src_valid,
  input wire logic      src_ready,
  input wire logic      dst_valid,
  input wire logic      dst_ready,
  input wire out_item_t dst_data
);

  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_data))
    else $error("result changed or dropped while stalled");

  a_ready_when_sink_ready: assert property (@(posedge clk) disable iff (rst)
    dst_ready |-> src_ready)
    else $error("request stalled while the output side is ready");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (src_valid && src_ready) ##1 dst_ready |=> dst_valid)
    else $error("accepted request did not reach the output in two cycles");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("result pending after reset");

endmodule

bind multichannel_delay_with_beep mdb_checker u_mdb_checker (.*);
`default_nettype wire

@@ test/tb_multichannel_delay_with_beep.sv @@
// Testbench for the multichannel delay line with mute beep, checked against a scoreboard.
`timescale 1ns / 100ps

import mdb_pkg::*;

class delay_beep_board;
  out_item_t                  expected_out[$];
  logic signed [SAMPLE_W-1:0] ring[int];
  logic [DELAY_REG_W-1:0]     delay_reg;
  logic [CHANNELS_REG_W-1:0]  chans_reg;
  logic [PHASE_W-1:0]         step_reg;
  logic [VOLUME_W-1:0]        volume_reg;
  int unsigned                frame_wr;
  int unsigned                frames_filled;
  int unsigned                ch_pos;
  logic [PHASE_W-1:0]         tone_phase;
  bit                         tone_on;
  logic signed [SAMPLE_W-1:0] tone_val;
  int unsigned                errors;
  int unsigned                checked;
  int unsigned                requests;
  int unsigned                beep_frames;

  function new();
    delay_reg   = '0;
    chans_reg   = 1;
    step_reg    = '0;
    volume_reg  = '0;
    tone_phase  = '0;
    errors      = 0;
    checked     = 0;
    requests    = 0;
    beep_frames = 0;
    restart();
  endfunction

  function void restart();
    frame_wr      = 0;
    frames_filled = 0;
    ch_pos        = 0;
    tone_on       = 0;
    tone_val      = '0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_DELAY_FRAMES: begin
        delay_reg = val[DELAY_REG_W-1:0];
        restart();
      end
      REG_CHANNEL_COUNT: begin
        chans_reg = val[CHANNELS_REG_W-1:0];
        restart();
      end
      REG_PHASE_STEP: begin
        step_reg = val[PHASE_W-1:0];
      end
      REG_BEEP_VOLUME: begin
        volume_reg = val[VOLUME_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  function logic [63:0] q30_mul(logic [63:0] a, logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function int tone_entry(int unsigned k);
    logic [63:0] coef[5];
    int unsigned quarter;
    int unsigned quad;
    int unsigned r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] mag;
    coef    = '{64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172273};
    quarter = 1 << (SINE_TABLE_BITS - 2);
    quad    = (k >> (SINE_TABLE_BITS - 2)) & 3;
    r       = k & (quarter - 1);
    if (quad[0]) begin
      r = quarter - r;
    end
    x   = 64'(r) << (30 - (SINE_TABLE_BITS - 2));
    x2  = q30_mul(x, x);
    acc = coef[4];
    for (int j = 3; j >= 0; j--) begin
      acc = coef[j] - q30_mul(x2, acc);
    end
    s = q30_mul(x, acc);
    if (s > (64'd1 << 30)) begin
      s = 64'd1 << 30;
    end
    mag = (s * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
    return quad[1] ? -int'(mag) : int'(mag);
  endfunction

  function logic signed [SAMPLE_W-1:0] next_tone();
    int          t;
    logic [63:0] mag;
    logic [63:0] v;
    t   = tone_entry(tone_phase >> (PHASE_W - SINE_TABLE_BITS));
    mag = (t < 0) ? 64'(-t) : 64'(t);
    v   = (mag * 64'(volume_reg) + 64'd32768) >> 16;
    tone_phase += step_reg;
    beep_frames++;
    return (t < 0) ? -SAMPLE_W'(v) : SAMPLE_W'(v);
  endfunction

  function void note_request(in_item_t req);
    int unsigned                chans;
    int unsigned                dly;
    int unsigned                ch;
    int unsigned                addr;
    logic signed [SAMPLE_W-1:0] delayed;
    logic signed [SAMPLE_W-1:0] result;
    out_item_t                  want;
    chans = chans_reg;
    dly   = delay_reg;
    if (chans < 1) chans = 1;
    if (chans > MAX_CHANNELS) chans = MAX_CHANNELS;
    if (dly > MAX_DELAY_FRAMES) dly = MAX_DELAY_FRAMES;
    if (ch_pos >= chans) ch_pos = 0;
    ch = ch_pos;
    if (dly == 0) begin
      result = req.sample;
    end else begin
      if (ch == 0) begin
        if (req.mute) begin
          tone_on  = 1;
          tone_val = next_tone();
        end else begin
          tone_on = 0;
        end
      end
      if (frame_wr >= dly) frame_wr = 0;
      addr = frame_wr * chans + ch;
      if (addr >= STORE_DEPTH) addr = 0;
      delayed = '0;
      if (frames_filled >= dly && ring.exists(addr)) delayed = ring[addr];
      ring[addr] = req.sample;
      result = tone_on ? tone_val : delayed;
      if (ch + 1 >= chans) begin
        frame_wr = (frame_wr + 1 >= dly) ? 0 : frame_wr + 1;
        if (frames_filled < dly) frames_filled++;
      end
    end
    ch_pos = (ch + 1 >= chans) ? 0 : ch + 1;
    want.sample_out = result;
    want.channel    = ch[CHANNEL_OUT_W-1:0];
    expected_out.push_back(want);
    requests++;
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (expected_out.size() == 0) begin
      $display("%0t: unexpected result: sample_out %0d channel %0d",
               $time, got.sample_out, got.channel);
      errors++;
      return;
    end
    want = expected_out.pop_front();
    checked++;
    if (got.sample_out !== want.sample_out) begin
      $display("%0t: sample_out mismatch: expected %0d, actual %0d",
               $time, want.sample_out, got.sample_out);
      errors++;
    end
    if (got.channel !== want.channel) begin
      $display("%0t: channel mismatch: expected %0d, actual %0d",
               $time, want.channel, got.channel);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_out.size();
  endfunction
endclass

module tb_multichannel_delay_with_beep;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RAND_PHASES  = 10;
  localparam int unsigned DRAIN_CYCLES = 6;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   src_valid = 1'b0;
  logic                   src_ready;
  in_item_t               src_data  = '0;
  logic                   dst_valid;
  logic                   dst_ready = 1'b0;
  out_item_t              dst_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  bit                     calm      = 1'b0;
  int unsigned            settings  = 0;
  delay_beep_board        board     = new();

  multichannel_delay_with_beep dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      dst_ready <= 1'b0;
    end else begin
      if (dst_valid && dst_ready) board.check_result(dst_data);
      dst_ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((src_valid && src_ready) || (dst_valid && dst_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  task automatic configure(logic [DELAY_REG_W-1:0] dly, logic [CHANNELS_REG_W-1:0] chn,
                           logic [PHASE_W-1:0] stp, logic [VOLUME_W-1:0] vol, bit keep);
    if (!keep) begin
      write_reg(REG_DELAY_FRAMES, ($urandom & 32'hFFFF_0000) | 32'(dly));
      write_reg(REG_CHANNEL_COUNT, ($urandom & 32'hFFFF_FFF0) | 32'(chn));
    end
    write_reg(REG_PHASE_STEP, stp);
    write_reg(REG_BEEP_VOLUME, ($urandom & 32'hFFFF_0000) | 32'(vol));
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic send_request(in_item_t req);
    if (!calm && $urandom_range(99) < 10) begin
      src_valid <= 1'b0;
      src_data  <= 25'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= req;
    do @(posedge clk); while (!src_ready);
    board.note_request(req);
  endtask

  // drop valid, wait out every pending result, then let the pipeline empty
  task automatic settle();
    src_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t rand_request();
    in_item_t r;
    case ($urandom_range(15))
      0:       r.sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
      1:       r.sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
      2:       r.sample = '0;
      default: r.sample = SAMPLE_W'($urandom);
    endcase
    r.mute = ($urandom_range(3) == 0);
    return r;
  endfunction

  task automatic send_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_request(rand_request());
    end
  endtask

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] corner_vals[5];
    in_item_t                   req;
    logic [DELAY_REG_W-1:0]     dly;
    logic [CHANNELS_REG_W-1:0]  chn;
    logic [PHASE_W-1:0]         stp;
    logic [VOLUME_W-1:0]        vol;
    bit                         keep;
    corner_vals = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, -24'sd1, 24'sd1};
    dly = '0;
    chn = 1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: pass through on one channel, mute ignored
    for (int i = 0; i < 4; i++) begin
      req.sample = corner_vals[i];
      req.mute   = i[0];
      send_request(req);
    end
    settle();

    // quarter-turn beep at full volume over three channels
    configure(16'd2, 4'd3, 32'h4000_0000, 16'hFFFF, 1'b0);
    for (int f = 0; f < 6; f++) begin
      for (int c = 0; c < 3; c++) begin
        req.sample = corner_vals[(f * 3 + c) % 5];
        req.mute   = (c == 0 && f != 1 && f != 2) || (f == 2 && c == 1);
        send_request(req);
      end
    end
    settle();

    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(9))
        0, 1:    dly = 1;
        2:       dly = 0;
        3:       dly = $urandom_range(25, 200);
        default: dly = $urandom_range(2, 24);
      endcase
      chn = $urandom_range(0, 15);
      case ($urandom_range(5))
        0:       stp = '0;
        1:       stp = '1;
        default: stp = $urandom;
      endcase
      case ($urandom_range(5))
        0:       vol = '0;
        1:       vol = '1;
        default: vol = $urandom_range(0, 65535);
      endcase
      if (p == 0) begin
        dly = 1;
        chn = MAX_CHANNELS;
      end
      if (p == 1) begin
        dly = 24;
        chn = 0;
      end
      keep = (p > 1) && ($urandom_range(3) == 0);
      calm = (p == 4 || p == 5);
      configure(dly, chn, stp, vol, keep);
      send_random($urandom_range(60, 140));
      settle();
    end
    calm = 1'b0;

    // clamp an oversized delay to the full ring and start filling it
    configure(16'hFFFF, 4'd1, $urandom, 16'hFFFF, 1'b0);
    send_random(64);
    settle();

    $display("Checked %0d results of %0d requests over %0d register settings, %0d beep frames.",
             board.checked, board.requests, settings, board.beep_frames);
    $display("Covered pass-through, short and clamped delays, clamped channel counts, stalls.");
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
